// ===== sv/apzt_pkg.sv =====
package apzt_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned SAMPLE_W = 63;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NOMINAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_BASE = 2'd2;

   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_PACKET = 1'b1;

   typedef struct packed {
      logic              start;
      logic              op;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] b;
   } muldiv_req_type;

   typedef struct packed {
      logic              done;
      logic              busy;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
   } muldiv_rsp_type;

endpackage

// ===== sv/apzt_muldiv.sv =====
// one bit per cycle: shift-add multiply (hi:lo = lo * b) or
// restoring divide (lo = hi:lo / b, hi = remainder), one shared adder
module apzt_muldiv (
   input  logic                    clock,
   input  logic                    reset,
   input  apzt_pkg::muldiv_req_type req_i,
   output apzt_pkg::muldiv_rsp_type rsp_o
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        op_ff, op_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [apzt_pkg::WORD_W-1:0] hi_ff, hi_in;
   logic [apzt_pkg::WORD_W-1:0] lo_ff, lo_in;
   logic [apzt_pkg::WORD_W-1:0] b_ff, b_in;

   logic [apzt_pkg::WORD_W:0]   add_x, add_y;
   logic                        add_cin;
   logic [apzt_pkg::WORD_W+1:0] add_res;
   logic                        ge;

   always_comb begin
      if (op_ff == apzt_pkg::OP_DIV) begin
         add_x = {hi_ff, lo_ff[apzt_pkg::WORD_W-1]};
         add_y = ~{1'b0, b_ff};
         add_cin = 1'b1;
      end else begin
         add_x = {1'b0, hi_ff};
         add_y = lo_ff[0] ? {1'b0, b_ff} : '0;
         add_cin = 1'b0;
      end
      add_res = {1'b0, add_x} + {1'b0, add_y} + {{(apzt_pkg::WORD_W+1){1'b0}}, add_cin};
      ge = add_res[apzt_pkg::WORD_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      b_in = b_ff;
      if (req_i.start) begin
         op_in = req_i.op;
         b_in = req_i.b;
         hi_in = req_i.hi;
         lo_in = req_i.lo;
         cnt_in = '0;
         if (req_i.op == apzt_pkg::OP_DIV && req_i.hi >= req_i.b) begin
            // quotient would not fit: saturate
            lo_in = '1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (op_ff == apzt_pkg::OP_DIV) begin
            hi_in = ge ? add_res[apzt_pkg::WORD_W-1:0] : add_x[apzt_pkg::WORD_W-1:0];
            lo_in = {lo_ff[apzt_pkg::WORD_W-2:0], ge};
         end else begin
            hi_in = add_res[apzt_pkg::WORD_W:1];
            lo_in = {add_res[0], lo_ff[apzt_pkg::WORD_W-1:1]};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      b_ff <= b_in;
   end

   assign rsp_o.done = done_ff;
   assign rsp_o.busy = busy_ff;
   assign rsp_o.hi = hi_ff;
   assign rsp_o.lo = lo_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_i.start |-> !busy_ff) else $error("start while busy");
   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == 6'd63 && !req_i.start) |=> (done_ff && !busy_ff))
      else $error("last step did not finish");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      req_i.start |=> (busy_ff || done_ff)) else $error("start lost");
   a_fell_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff) else $error("busy ended without done");

endmodule

// ===== sv/audio_period_zero_timestamper.sv =====
// audio period zero timestamper
// req channel: req_tuser = func (0 observe frame/host pair, 1 packet),
// req_tdata = frame_index, host_time, frame_count.
// rsp channel: one item per packet, none per observe item;
// rsp_tuser = published, rsp_tdata = zero_sample, zero_host.
// csr port: csr_we writes csr_wdata to register csr_index (0 nominal ticks
// per frame, 1 period samples, 2 min baseline frames); write only when idle.
// an observe item is taken in idle and does not leave it. a packet with no
// boundary in it passes align, check and out, with an align divide first if
// the boundary fell behind. a publishing packet passes check, host multiply,
// offset multiply and scaled divide, with a measured-rate divide first when
// the baseline allows (it finishes without stepping when that rate saturates);
// the shared bit-serial multiply/divide unit runs each of up to five operations
// (align remainder, measured rate, host of frame, offset product, scaled divide).
// req_tready is low from packet acceptance until its result is taken; a
// stalled rsp_tready holds the result and keeps the input blocked.
// reset (synchronous) clears the anchor, pair, counters and restores the
// register defaults; no clearing pass is needed.
module audio_period_zero_timestamper #(
   parameter int unsigned RATE_FRAC_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,  // frame_index, host_time, frame_count
   input  logic          req_tuser,  // func
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,  // zero_sample, zero_host, zero pad
   output logic          rsp_tuser,  // published
   input  logic          csr_we,
   input  logic [apzt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]   csr_wdata
);

   localparam int unsigned W = apzt_pkg::WORD_W;
   localparam int unsigned CW = apzt_pkg::COUNT_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ALIGN = 4'd1;
   localparam logic [3:0] S_ALIGN_WAIT = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_RATE_WAIT = 4'd4;
   localparam logic [3:0] S_HOST_MUL = 4'd5;
   localparam logic [3:0] S_HOST_WAIT = 4'd6;
   localparam logic [3:0] S_K_MUL = 4'd7;
   localparam logic [3:0] S_K_WAIT = 4'd8;
   localparam logic [3:0] S_SCALE_DIV = 4'd9;
   localparam logic [3:0] S_DIV_WAIT = 4'd10;
   localparam logic [3:0] S_OUT = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [W-1:0]  nominal_ff, nominal_in;
   logic [CW-1:0] period_ff, period_in;
   logic [CW-1:0] min_base_ff, min_base_in;
   logic          anchored_ff, anchored_in;
   logic [W-1:0]  anchor_frame_ff, anchor_frame_in;
   logic [W-1:0]  anchor_host_ff, anchor_host_in;
   logic [W-1:0]  latest_frame_ff, latest_frame_in;
   logic [W-1:0]  latest_host_ff, latest_host_in;
   logic [W-1:0]  next_bound_ff, next_bound_in;
   logic [W-1:0]  total_ff, total_in;
   logic [W-1:0]  frame_ff, frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;
   logic [W-1:0]  rate_ff, rate_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  host_ff, host_in;
   logic          pub_ff, pub_in;
   logic [apzt_pkg::SAMPLE_W-1:0] zs_ff, zs_in;
   logic [W-1:0]  zh_ff, zh_in;

   apzt_pkg::muldiv_req_type md_req;
   apzt_pkg::muldiv_rsp_type md_rsp;

   logic [W-1:0]   in_frame, in_host;
   logic [CW-1:0]  in_count;
   logic [CW-1:0]  per;
   logic [W-1:0]   gap, span, dh, dframe, mag, prod_q, q_host;
   logic [2*W-1:0] dh_num, prod;
   logic           measured, pub_cond;

   assign in_frame = req_tdata[63:0];
   assign in_host = req_tdata[127:64];
   assign in_count = req_tdata[143:128];
   assign per = (period_ff == '0) ? {{(CW-1){1'b0}}, 1'b1} : period_ff;

   always_comb begin
      gap = next_bound_ff - total_ff;
      span = latest_frame_ff - anchor_frame_ff;
      dh = latest_host_ff - anchor_host_ff;
      dh_num = {{W{1'b0}}, dh} << RATE_FRAC_BITS;
      measured = anchored_ff && (latest_frame_ff >= anchor_frame_ff)
         && (latest_host_ff > anchor_host_ff) && (span != '0)
         && (span >= {{(W-CW){1'b0}}, min_base_ff});
      pub_cond = anchored_ff && (count_ff != '0) && (next_bound_ff >= total_ff)
         && (gap < {{(W-CW){1'b0}}, count_ff});
      dframe = frame_ff - anchor_frame_ff;
      mag = dframe[W-1] ? (W'(0) - dframe) : dframe;
      prod = {md_rsp.hi, md_rsp.lo};
      prod_q = prod[RATE_FRAC_BITS +: W];
      q_host = prod_q + {{(W-1){1'b0}}, (neg_ff && (prod[RATE_FRAC_BITS-1:0] != '0))};
   end

   always_comb begin
      state_in = state_ff;
      nominal_in = nominal_ff;
      period_in = period_ff;
      min_base_in = min_base_ff;
      anchored_in = anchored_ff;
      anchor_frame_in = anchor_frame_ff;
      anchor_host_in = anchor_host_ff;
      latest_frame_in = latest_frame_ff;
      latest_host_in = latest_host_ff;
      next_bound_in = next_bound_ff;
      total_in = total_ff;
      frame_in = frame_ff;
      count_in = count_ff;
      k_in = k_ff;
      rate_in = rate_ff;
      neg_in = neg_ff;
      host_in = host_ff;
      pub_in = pub_ff;
      zs_in = zs_ff;
      zh_in = zh_ff;
      md_req = '0;

      if (csr_we) begin
         unique case (csr_index)
            apzt_pkg::CSR_NOMINAL: nominal_in = csr_wdata;
            apzt_pkg::CSR_PERIOD: period_in = csr_wdata[CW-1:0];
            apzt_pkg::CSR_MIN_BASE: min_base_in = csr_wdata[CW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == apzt_pkg::FUNC_OBSERVE) begin
                  if (!anchored_ff) begin
                     anchored_in = 1'b1;
                     anchor_frame_in = in_frame;
                     anchor_host_in = in_host;
                  end
                  if (!anchored_ff || in_frame > latest_frame_ff) begin
                     latest_frame_in = in_frame;
                     latest_host_in = in_host;
                  end
               end else begin
                  frame_in = in_frame;
                  count_in = in_count;
                  state_in = S_ALIGN;
               end
            end
         end
         S_ALIGN: begin
            if (next_bound_ff < total_ff) begin
               md_req.start = 1'b1;
               md_req.op = apzt_pkg::OP_DIV;
               md_req.hi = '0;
               md_req.lo = total_ff - next_bound_ff;
               md_req.b = {{(W-CW){1'b0}}, per};
               state_in = S_ALIGN_WAIT;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_ALIGN_WAIT: begin
            if (md_rsp.done) begin
               // round up to the period grid: add (per - rem) when rem is nonzero
               next_bound_in = total_ff + ((md_rsp.hi == '0) ? '0
                  : ({{(W-CW){1'b0}}, per} - md_rsp.hi));
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (pub_cond) begin
               k_in = gap[CW-1:0];
               if (measured) begin
                  md_req.start = 1'b1;
                  md_req.op = apzt_pkg::OP_DIV;
                  md_req.hi = dh_num[2*W-1:W];
                  md_req.lo = dh_num[W-1:0];
                  md_req.b = span;
                  state_in = S_RATE_WAIT;
               end else begin
                  rate_in = nominal_ff;
                  state_in = S_HOST_MUL;
               end
            end else begin
               pub_in = 1'b0;
               zs_in = '0;
               zh_in = '0;
               total_in = total_ff + {{(W-CW){1'b0}}, count_ff};
               state_in = S_OUT;
            end
         end
         S_RATE_WAIT: begin
            if (md_rsp.done) begin
               rate_in = md_rsp.lo;
               state_in = S_HOST_MUL;
            end
         end
         S_HOST_MUL: begin
            neg_in = dframe[W-1];
            md_req.start = 1'b1;
            md_req.op = apzt_pkg::OP_MUL;
            md_req.hi = '0;
            md_req.lo = mag;
            md_req.b = rate_ff;
            state_in = S_HOST_WAIT;
         end
         S_HOST_WAIT: begin
            if (md_rsp.done) begin
               host_in = neg_ff ? (anchor_host_ff - q_host) : (anchor_host_ff + q_host);
               state_in = S_K_MUL;
            end
         end
         S_K_MUL: begin
            md_req.start = 1'b1;
            md_req.op = apzt_pkg::OP_MUL;
            md_req.hi = '0;
            md_req.lo = {{(W-CW){1'b0}}, k_ff};
            md_req.b = rate_ff;
            state_in = S_K_WAIT;
         end
         S_K_WAIT: begin
            if (md_rsp.done) begin
               state_in = S_SCALE_DIV;
            end
         end
         S_SCALE_DIV: begin
            md_req.start = 1'b1;
            md_req.op = apzt_pkg::OP_DIV;
            md_req.hi = '0;
            md_req.lo = prod_q;
            md_req.b = {{(W-CW){1'b0}}, count_ff};
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (md_rsp.done) begin
               pub_in = 1'b1;
               zs_in = next_bound_ff[apzt_pkg::SAMPLE_W-1:0];
               zh_in = host_ff + md_rsp.lo;
               next_bound_in = next_bound_ff + {{(W-CW){1'b0}}, per};
               total_in = total_ff + {{(W-CW){1'b0}}, count_ff};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nominal_ff <= W'(500) << RATE_FRAC_BITS;
         period_ff <= CW'(512);
         min_base_ff <= CW'(48);
         anchored_ff <= 1'b0;
         anchor_frame_ff <= '0;
         anchor_host_ff <= '0;
         latest_frame_ff <= '0;
         latest_host_ff <= '0;
         next_bound_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         nominal_ff <= nominal_in;
         period_ff <= period_in;
         min_base_ff <= min_base_in;
         anchored_ff <= anchored_in;
         anchor_frame_ff <= anchor_frame_in;
         anchor_host_ff <= anchor_host_in;
         latest_frame_ff <= latest_frame_in;
         latest_host_ff <= latest_host_in;
         next_bound_ff <= next_bound_in;
         total_ff <= total_in;
      end
      frame_ff <= frame_in;
      count_ff <= count_in;
      k_ff <= k_in;
      rate_ff <= rate_in;
      neg_ff <= neg_in;
      host_ff <= host_in;
      pub_ff <= pub_in;
      zs_ff <= zs_in;
      zh_ff <= zh_in;
   end

   apzt_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req_i (md_req),
      .rsp_o (md_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser = pub_ff;
   assign rsp_tdata = {1'b0, zh_ff, zs_ff};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input open while result waits");
   a_pub_anchored: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> anchored_ff) else $error("published unanchored");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int unsigned FRAC = 32;
   localparam int unsigned SETTLE = 400;

   typedef struct packed {
      logic              published;
      logic [62:0]       zero_sample;
      logic [63:0]       zero_host;
   } stamp_type;

   typedef struct {
      logic        func;
      logic [63:0] frame;
      logic [63:0] host;
      logic [15:0] count;
      bit          typed;
      stamp_type   stamp;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;  // frame_index, host_time, frame_count
   logic          req_tuser = 1'b0;  // func
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;  // zero_sample, zero_host, zero pad
   logic          rsp_tuser;  // published
   logic          csr_we = 1'b0;
   logic [apzt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]   csr_wdata = '0;

   // predictor copy of the block
   logic [63:0] m_nominal, m_period, m_min_base;
   bit          m_anchored;
   logic [63:0] m_anchor_frame, m_anchor_host, m_latest_frame, m_latest_host;
   logic [63:0] m_next_boundary, m_sample_total;

   stamp_type pending_stamps[$];
   int        mismatches = 0;
   int        snd_idle = 0;
   int        rcv_idle = 0;

   audio_period_zero_timestamper i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] ticks_per_frame();
      logic [63:0]  span, dh;
      logic [127:0] num;
      if (!m_anchored || m_latest_frame < m_anchor_frame || m_latest_host <= m_anchor_host)
         return m_nominal;
      span = m_latest_frame - m_anchor_frame;
      if (span == 0 || span < m_min_base) return m_nominal;
      dh = m_latest_host - m_anchor_host;
      if ((dh >> (64 - FRAC)) >= span) return '1;
      num = {64'd0, dh} << FRAC;
      return 64'(num / {64'd0, span});
   endfunction

   function automatic logic [63:0] host_at_frame(logic [63:0] frame, logic [63:0] rate);
      logic [63:0]  d, mag, q;
      logic [127:0] prod;
      d = frame - m_anchor_frame;
      mag = d[63] ? -d : d;
      prod = {64'd0, mag} * {64'd0, rate};
      q = prod[FRAC +: 64];
      if (d[63]) begin
         if (prod[FRAC-1:0] != 0) q = q + 1;
         return m_anchor_host - q;
      end
      return m_anchor_host + q;
   endfunction

   task automatic stamp_predict(input logic func, input logic [63:0] frame,
                                input logic [63:0] host, input logic [15:0] count,
                                output bit has_stamp, output stamp_type stamp);
      logic [63:0]  per, behind, steps, k, rate, scaled;
      logic [127:0] prod;
      bit           first;
      per = (m_period == 0) ? 64'd1 : m_period;
      stamp = '0;
      has_stamp = 0;
      if (func == apzt_pkg::FUNC_OBSERVE) begin
         first = !m_anchored;
         if (first) begin
            m_anchored = 1;
            m_anchor_frame = frame;
            m_anchor_host = host;
         end
         if (first || frame > m_latest_frame) begin
            m_latest_frame = frame;
            m_latest_host = host;
         end
         return;
      end
      has_stamp = 1;
      if (m_next_boundary < m_sample_total) begin
         behind = m_sample_total - m_next_boundary;
         steps = behind / per + ((behind % per) != 0);
         m_next_boundary = m_next_boundary + steps * per;
      end
      k = m_next_boundary - m_sample_total;
      if (m_anchored && count > 0 && m_next_boundary >= m_sample_total && k < count) begin
         rate = ticks_per_frame();
         prod = {64'd0, k} * {64'd0, rate};
         scaled = prod[FRAC +: 64];
         stamp.published = 1'b1;
         stamp.zero_sample = m_next_boundary[62:0];
         stamp.zero_host = host_at_frame(frame, rate) + scaled / count;
         m_next_boundary = m_next_boundary + per;
      end
      m_sample_total = m_sample_total + count;
   endtask

   task automatic csr_write(input logic [apzt_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         apzt_pkg::CSR_NOMINAL: m_nominal = val;
         apzt_pkg::CSR_PERIOD: m_period = val & 64'hFFFF;
         apzt_pkg::CSR_MIN_BASE: m_min_base = val & 64'hFFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input logic func, input logic [63:0] frame,
                            input logic [63:0] host, input logic [15:0] count,
                            input bit typed, input stamp_type typed_stamp);
      bit        has_stamp;
      stamp_type stamp;
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {count, host, frame};
      do @(posedge clock); while (!req_tready);
      stamp_predict(func, frame, host, count, has_stamp, stamp);
      if (has_stamp) pending_stamps.push_back(typed ? typed_stamp : stamp);
      if ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_stamps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      stamp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stamps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: tuser=%0d tdata=%h",
                                           rsp_tuser, rsp_tdata);
         end else begin
            want = pending_stamps.pop_front();
            if (rsp_tuser !== want.published || rsp_tdata[62:0] !== want.zero_sample ||
                rsp_tdata[126:63] !== want.zero_host) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pub=%0d zs=%h zh=%h got pub=%0d zs=%h zh=%h",
                           want.published, want.zero_sample, want.zero_host,
                           rsp_tuser, rsp_tdata[62:0], rsp_tdata[126:63]);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      stamp_type    none;
      logic [63:0]  sf, fbase, hbase, tpf, frm, hst;
      logic [15:0]  cnt;
      int           pick;
      logic [63:0]  cfg_nom[6];
      logic [63:0]  cfg_per[6];
      logic [63:0]  cfg_min[6];

      m_nominal = 64'd500 << FRAC;
      m_period = 64'd512;
      m_min_base = 64'd48;
      m_anchored = 0;
      {m_anchor_frame, m_anchor_host, m_latest_frame, m_latest_host} = '0;
      {m_next_boundary, m_sample_total} = '0;
      none = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part on register defaults
      rows = '{
         '{apzt_pkg::FUNC_PACKET, 64'd0, 64'd0, 16'd100, 1, none},        // unanchored
         '{apzt_pkg::FUNC_PACKET, 64'd5, 64'd0, 16'd0, 1, none},   // unanchored, empty
         '{apzt_pkg::FUNC_PACKET, '1, '1, 16'hFFFF, 1, none},      // unanchored, widest
         '{apzt_pkg::FUNC_OBSERVE, 64'd1000, 64'd500000, 16'd0, 0, none}, // anchor
         '{apzt_pkg::FUNC_PACKET, 64'd1000, 64'd0, 16'd600, 0, none},  // boundary behind
         '{apzt_pkg::FUNC_OBSERVE, 64'd900, 64'd1, 16'd0, 0, none},    // older frame
         '{apzt_pkg::FUNC_PACKET, 64'd900, 64'd0, 16'd512, 0, none},   // before anchor
         '{apzt_pkg::FUNC_OBSERVE, 64'd1100, 64'd550000, 16'd0, 0, none}, // measured
         '{apzt_pkg::FUNC_PACKET, 64'd2000, 64'd0, 16'd0, 1, none},    // empty packet
         '{apzt_pkg::FUNC_PACKET, 64'd2000, '1, 16'hFFFF, 0, none},
         '{apzt_pkg::FUNC_PACKET, 64'd1101, 64'd0, 16'd1, 0, none},
         '{apzt_pkg::FUNC_OBSERVE, '1, '1, 16'hFFFF, 0, none},
         '{apzt_pkg::FUNC_PACKET, '1, 64'd0, 16'd1, 0, none},
         '{apzt_pkg::FUNC_PACKET, 64'd0, 64'd0, 16'hFFFF, 0, none},
         '{apzt_pkg::FUNC_PACKET, 64'h8000_0000_0000_0000, 64'd0, 16'd700, 0, none}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send_item(r.func, r.frame, r.host, r.count, r.typed, r.stamp);
      end
      drain();

      cfg_nom = '{64'd1, '1, 64'd48 << FRAC, 64'd20833 << FRAC, 64'h0000_01F4_8000_0000,
                  64'd500 << FRAC};
      cfg_per = '{64'd1, 64'd65535, 64'd480, 64'd64, 64'd512, 64'd1024};
      cfg_min = '{64'd1, 64'd65535, 64'd48, 64'd1, 64'd200, 64'd65535};

      sf = {32'd0, $urandom()};
      fbase = m_anchor_frame;
      hbase = m_anchor_host;
      for (int ph = 0; ph < 6; ph++) begin
         snd_idle = (ph < 2) ? 12 : (ph < 4) ? 73 : 0;
         rcv_idle = (ph < 2) ? 73 : (ph < 4) ? 12 : 0;
         csr_write(apzt_pkg::CSR_NOMINAL, cfg_nom[ph]);
         csr_write(apzt_pkg::CSR_PERIOD, cfg_per[ph]);
         csr_write(apzt_pkg::CSR_MIN_BASE, cfg_min[ph]);
         tpf = $urandom_range(400, 600);
         for (int n = 0; n < 280; n++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               // noise, all bits free
               send_item(logic'($urandom_range(1)), {$urandom(), $urandom()},
                         {$urandom(), $urandom()}, 16'($urandom()), 0, none);
            end else if (pick < 30) begin
               frm = sf + $urandom_range(0, 64);
               hst = hbase + (frm - fbase) * tpf + $urandom_range(0, 40);
               send_item(apzt_pkg::FUNC_OBSERVE, frm, hst, 16'($urandom()), 0, none);
            end else begin
               pick = $urandom_range(99);
               cnt = (pick < 4) ? 16'd0 : (pick < 8) ? 16'hFFFF :
                     (pick < 20) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(32, 600));
               send_item(apzt_pkg::FUNC_PACKET, sf, {$urandom(), $urandom()}, cnt, 0, none);
               sf = sf + cnt;
            end
         end
         // hold off until every result has come back before reconfiguring
         drain();
      end

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
